### rtl/core/rf_remote_pulse_width_decoder_macros.svh
// Assertion macros shared by the pulse width decoder RTL.
// Needs nothing else; include by bare file name inside a module body.
`ifndef RF_REMOTE_PULSE_WIDTH_DECODER_MACROS_SVH
`define RF_REMOTE_PULSE_WIDTH_DECODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RFPWD_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition leads to a consequence on the next edge.
`define RFPWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rfpwd_pkg.sv
// Types and constants of the RF remote pulse width decoder.
// Used by every module under rtl/core; depends on nothing.
package rfpwd_pkg;

    localparam int CNT_W   = 6;
    localparam int KEY_W   = 32;
    localparam int INDEX_W = 2;

    localparam logic [CNT_W-1:0] MAX_BITS = 6'd32;

    localparam logic [CNT_W-1:0] IDLE_LIMIT_RST    = 6'd32;
    localparam logic [CNT_W-1:0] ONE_THRESHOLD_RST = 6'd8;
    localparam logic [CNT_W-1:0] FRAME_BITS_RST    = 6'd25;

    typedef enum logic [INDEX_W-1:0] {
        CFG_IDLE_LIMIT    = 2'd0,
        CFG_ONE_THRESHOLD = 2'd1,
        CFG_FRAME_BITS    = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [CNT_W-1:0] idle_limit;
        logic [CNT_W-1:0] one_threshold;
        logic [CNT_W-1:0] frame_bits;
    } t_cfg;

    typedef struct packed {
        logic [KEY_W-1:0] key_value;
        logic             key_changed;
    } t_result;

endpackage

### rtl/core/rf_remote_pulse_width_decoder.sv
// Top level of the RF remote pulse width decoder: input register, decode, result register.
// Depends on rfpwd_pkg, rfpwd_cfg_regs, rfpwd_decode and rfpwd_out_reg.
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata[0] pin_level
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata key_value, tuser key_changed
// cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One request per cycle sustained while m_axis_tready stays high; each accepted sample gives one result.
// Latency is set by the input register and the result register around the decode logic.
// Reset is synchronous and active low; all counts, words and the key clear, registers
// take their reset values. A stalled output holds the result and backs up the input
// register, so s_axis_tready falls only while both stages are full.
module rf_remote_pulse_width_decoder import rfpwd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [0] pin_level, [7:1] zero
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [KEY_W-1:0]   m_axis_tdata,   // [31:0] key_value
    output logic               m_axis_tuser,   // [0] key_changed
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [INDEX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]   i_cfg_data
);

    logic    r_in_valid;
    logic    n_in_valid;
    logic    r_in_level;
    logic    w_free;
    logic    w_step;
    logic    w_in_take;
    t_cfg    w_cfg;
    t_result w_result;
    t_result w_out_result;

    assign o_cfg_ready   = 1'b1;
    assign w_step        = r_in_valid && w_free;
    assign s_axis_tready = !r_in_valid || w_free;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_level <= s_axis_tdata[0];
        end
    end

    rfpwd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    rfpwd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_level  (r_in_level),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    rfpwd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step),
        .i_result (w_result),
        .i_ready  (m_axis_tready),
        .o_free   (w_free),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out_result)
    );

    assign m_axis_tdata = w_out_result.key_value;
    assign m_axis_tuser = w_out_result.key_changed;

endmodule

### rtl/core/rfpwd_cfg_regs.sv
// Configuration register file of the pulse width decoder.
// Depends on rfpwd_pkg.
module rfpwd_cfg_regs import rfpwd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [INDEX_W-1:0]   i_wr_index,
    input  logic [CNT_W-1:0]     i_wr_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_cfg_index'(i_wr_index))
                CFG_IDLE_LIMIT:    n_cfg.idle_limit    = i_wr_data;
                CFG_ONE_THRESHOLD: n_cfg.one_threshold = i_wr_data;
                CFG_FRAME_BITS:    n_cfg.frame_bits    = i_wr_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_limit    <= IDLE_LIMIT_RST;
            r_cfg.one_threshold <= ONE_THRESHOLD_RST;
            r_cfg.frame_bits    <= FRAME_BITS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/rfpwd_decode.sv
// Pulse width measurement, bit assembly and key hold of the decoder.
// Depends on rfpwd_pkg and rf_remote_pulse_width_decoder_macros.svh.
module rfpwd_decode import rfpwd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  logic     i_level,
    input  t_cfg     i_cfg,
    output t_result  o_result
);

    logic [CNT_W-1:0] r_low_ticks,  n_low_ticks;
    logic [CNT_W-1:0] r_high_ticks, n_high_ticks;
    logic             r_last_level, n_last_level;
    logic [CNT_W-1:0] r_high_time,  n_high_time;
    logic [CNT_W-1:0] r_bits_seen,  n_bits_seen;
    logic [KEY_W-1:0] r_shift_word, n_shift_word;
    logic [KEY_W-1:0] r_held_key,   n_held_key;

    always_comb begin
        n_low_ticks  = r_low_ticks;
        n_high_ticks = r_high_ticks;
        n_last_level = r_last_level;
        n_high_time  = r_high_time;
        n_bits_seen  = r_bits_seen;
        n_shift_word = r_shift_word;
        n_held_key   = r_held_key;
        if (i_step) begin
            if (!i_level) begin
                if (r_low_ticks < i_cfg.idle_limit) begin
                    n_low_ticks = r_low_ticks + 6'd1;
                    // end of frame: latch the word only on an exact bit count
                    if (n_low_ticks >= i_cfg.idle_limit) begin
                        n_held_key   = (r_bits_seen == i_cfg.frame_bits) ? r_shift_word
                                                                         : '0;
                        n_shift_word = '0;
                        n_bits_seen  = '0;
                    end
                    n_high_ticks = '0;
                    if (r_last_level) begin
                        n_last_level = 1'b0;
                        if (r_high_time >= i_cfg.one_threshold) begin
                            n_shift_word = n_shift_word | {{(KEY_W-1){1'b0}}, 1'b1};
                        end
                        if (n_bits_seen < MAX_BITS) begin
                            n_bits_seen = n_bits_seen + 6'd1;
                        end
                    end
                end
            end else begin
                if (r_high_ticks < i_cfg.idle_limit) begin
                    n_high_ticks = r_high_ticks + 6'd1;
                    // long high level: abort the frame and drop the key
                    if (n_high_ticks >= i_cfg.idle_limit) begin
                        n_shift_word = '0;
                        n_held_key   = '0;
                        n_bits_seen  = '0;
                    end
                    n_low_ticks = '0;
                    if (!r_last_level) begin
                        n_last_level = 1'b1;
                        n_high_time  = '0;
                        n_shift_word = {n_shift_word[KEY_W-2:0], 1'b0};
                    end else begin
                        n_high_time = r_high_time + 6'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_ticks  <= '0;
            r_high_ticks <= '0;
            r_last_level <= 1'b0;
            r_high_time  <= '0;
            r_bits_seen  <= '0;
            r_shift_word <= '0;
            r_held_key   <= '0;
        end else begin
            r_low_ticks  <= n_low_ticks;
            r_high_ticks <= n_high_ticks;
            r_last_level <= n_last_level;
            r_high_time  <= n_high_time;
            r_bits_seen  <= n_bits_seen;
            r_shift_word <= n_shift_word;
            r_held_key   <= n_held_key;
        end
    end

    assign o_result.key_value   = n_held_key;
    assign o_result.key_changed = (n_held_key != r_held_key);

`include "rf_remote_pulse_width_decoder_macros.svh"

    `RFPWD_ASSERT_ALWAYS(a_bits_bounded, i_clk, i_rst_n, r_bits_seen <= MAX_BITS, "bit count above 32")
    `RFPWD_ASSERT_ALWAYS(a_one_count_live, i_clk, i_rst_n, (r_low_ticks == '0) || (r_high_ticks == '0), "low and high counts both running")
    `RFPWD_ASSERT_NEXT(a_key_needs_step, i_clk, i_rst_n, !i_step, $stable(r_held_key), "key moved without a sample")

endmodule

### rtl/core/rfpwd_out_reg.sv
// Result register of the pulse width decoder, parting decode from the output stream.
// Depends on rfpwd_pkg.
module rfpwd_out_reg import rfpwd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_result  i_result,
    input  logic     i_ready,
    output logic     o_free,
    output logic     o_valid,
    output t_result  o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### tb/testbench.sv
// Self-checking testbench for rf_remote_pulse_width_decoder: drives pin samples on the
// input stream, predicts key value and change flag per sample, checks the result stream.
// Depends on rfpwd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module testbench;
    import rfpwd_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'd0;   // [0] pin_level, [7:1] zero
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [KEY_W-1:0]   m_axis_tdata;          // [31:0] key_value
    logic               m_axis_tuser;          // [0] key_changed
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [INDEX_W-1:0] i_cfg_index = CFG_IDLE_LIMIT;
    logic [CNT_W-1:0]   i_cfg_data = '0;

    rf_remote_pulse_width_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // decoder state as predicted
    logic [CNT_W-1:0] cfg_idle  = IDLE_LIMIT_RST;
    logic [CNT_W-1:0] cfg_thr   = ONE_THRESHOLD_RST;
    logic [CNT_W-1:0] cfg_frame = FRAME_BITS_RST;
    logic [CNT_W-1:0] low_cnt   = '0;
    logic [CNT_W-1:0] high_cnt  = '0;
    logic [CNT_W-1:0] high_len  = '0;
    logic [CNT_W-1:0] bit_cnt   = '0;
    logic             last_pin  = 1'b0;
    logic [KEY_W-1:0] shift_reg = '0;
    logic [KEY_W-1:0] key_reg   = '0;

    logic    pin_q[$];
    t_result pending_keys[$];
    int      pushed_total = 0;
    int      err_count = 0;
    int      send_gap = 0;
    int      stall_left = 0;
    bit      no_idle = 1'b0;
    bit      hold_input = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_result decode_sample(input logic pin);
        t_result          r;
        logic [KEY_W-1:0] prev;
        prev = key_reg;
        if (!pin) begin
            if (low_cnt < cfg_idle) begin
                low_cnt = low_cnt + 6'd1;
                if (low_cnt >= cfg_idle) begin
                    key_reg   = (bit_cnt == cfg_frame) ? shift_reg : '0;
                    shift_reg = '0;
                    bit_cnt   = '0;
                end
                high_cnt = '0;
                if (last_pin) begin
                    last_pin = 1'b0;
                    if (high_len >= cfg_thr)
                        shift_reg[0] = 1'b1;
                    if (bit_cnt < MAX_BITS)
                        bit_cnt = bit_cnt + 6'd1;
                end
            end
        end else begin
            if (high_cnt < cfg_idle) begin
                high_cnt = high_cnt + 6'd1;
                if (high_cnt >= cfg_idle) begin
                    shift_reg = '0;
                    key_reg   = '0;
                    bit_cnt   = '0;
                end
                low_cnt = '0;
                if (!last_pin) begin
                    last_pin  = 1'b1;
                    high_len  = '0;
                    shift_reg = shift_reg << 1;
                end else begin
                    high_len = high_len + 6'd1;
                end
            end
        end
        r.key_value   = key_reg;
        r.key_changed = (key_reg != prev);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                pending_keys.push_back(decode_sample(s_axis_tdata[0]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pin_q.size() > 0 && !hold_input) begin
                    s_axis_tdata  <= {7'd0, pin_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_keys.size() == 0) begin
                    err_count = err_count + 1;
                    if (err_count <= 10)
                        $display("unexpected result: key %h changed %b",
                                 m_axis_tdata, m_axis_tuser);
                end else begin
                    want = pending_keys.pop_front();
                    if (m_axis_tdata !== want.key_value || m_axis_tuser !== want.key_changed) begin
                        err_count = err_count + 1;
                        if (err_count <= 10)
                            $display("mismatch: key exp %h got %h, changed exp %b got %b",
                                     want.key_value, m_axis_tdata,
                                     want.key_changed, m_axis_tuser);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic cfg_write(input t_cfg_index idx, input logic [CNT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_IDLE_LIMIT:    cfg_idle  = val;
            CFG_ONE_THRESHOLD: cfg_thr   = val;
            CFG_FRAME_BITS:    cfg_frame = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pin_q.size() != 0 || s_axis_tvalid || pending_keys.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_run(input logic level, input int n);
        repeat (n) pin_q.push_back(level);
        pushed_total = pushed_total + n;
    endtask

    task automatic push_frame(input int nbits, input bit clean);
        int lim, zmax, omin, omax, len;
        lim  = (cfg_idle > 1) ? cfg_idle - 1 : 1;
        zmax = (cfg_thr < lim) ? cfg_thr : lim;
        if (zmax < 1)
            zmax = 1;
        omax = (cfg_thr + 3 < lim) ? cfg_thr + 3 : lim;
        omin = (cfg_thr + 1 < omax) ? cfg_thr + 1 : omax;
        for (int b = 0; b < nbits; b++) begin
            if (!clean)
                len = $urandom_range(1, cfg_idle + 2);
            else if ($urandom_range(0, 1))
                len = $urandom_range(omin, omax);
            else if (zmax <= 12 && $urandom_range(0, 3) == 0)
                len = zmax;
            else
                len = $urandom_range(1, (zmax < 6) ? zmax : 6);
            push_run(1'b1, len);
            if (b < nbits - 1) begin
                if (clean)
                    push_run(1'b0, $urandom_range(1, (lim < 3) ? lim : 3));
                else
                    push_run(1'b0, $urandom_range(1, cfg_idle + 1));
            end
        end
        push_run(1'b0, cfg_idle + $urandom_range((cfg_idle == 0) ? 1 : 0, 3));
    endtask

    task automatic fill_items(input int budget);
        int start, r, nb;
        start = pushed_total;
        while (pushed_total - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                nb = cfg_frame;
                if (cfg_frame > MAX_BITS || $urandom_range(0, 4) == 0)
                    nb = $urandom_range(0, 33);
                push_frame(nb, 1'b1);
            end else if (r < 82) begin
                repeat ($urandom_range(1, 20)) push_run(1'($urandom_range(0, 1)), 1);
            end else if (r < 92) begin
                push_frame($urandom_range(0, 6), 1'b0);
            end else begin
                push_run(1'b1, cfg_idle + $urandom_range(0, 5));
                push_run(1'b0, $urandom_range(1, 4));
            end
        end
    endtask

    initial begin : stimulus
        int ph_idle[8]   = '{32, 1, 6, 12, 63, 10, 0, 8};
        int ph_thr[8]    = '{8, 0, 2, 3, 4, 3, 5, 0};
        int ph_frame[8]  = '{25, 0, 5, 16, 6, 63, 4, 3};
        int ph_budget[8] = '{1, 40, 40, 40, 1, 40, 30, 40};
        bit ph_burst[8]  = '{0, 0, 1, 0, 0, 0, 0, 1};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short frames: a one, a zero, frame end, abort, held levels, bad count
        cfg_write(CFG_IDLE_LIMIT, 6'd4);
        cfg_write(CFG_ONE_THRESHOLD, 6'd1);
        cfg_write(CFG_FRAME_BITS, 6'd2);
        cfg_write(CFG_UNUSED, 6'($urandom_range(0, 63)));
        push_run(1'b1, 2);
        push_run(1'b0, 1);
        push_run(1'b1, 1);
        push_run(1'b0, 5);
        push_run(1'b1, 5);
        push_run(1'b0, 5);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            cfg_write(CFG_IDLE_LIMIT, 6'(ph_idle[p]));
            cfg_write(CFG_ONE_THRESHOLD, 6'(ph_thr[p]));
            cfg_write(CFG_FRAME_BITS, 6'(ph_frame[p]));
            no_idle = ph_burst[p];
            if (p == 3) begin
                fill_items(ph_budget[p] / 2);
                // hold the sender until the decoder has drained
                while (pin_q.size() > 5) @(posedge i_clk);
                @(negedge i_clk) hold_input = 1'b1;
                do @(negedge i_clk); while (s_axis_tvalid || pending_keys.size() != 0);
                repeat (6) @(negedge i_clk);
                hold_input = 1'b0;
                fill_items(ph_budget[p] - ph_budget[p] / 2);
            end else begin
                fill_items(ph_budget[p]);
            end
            push_run(1'($urandom_range(0, 1)), $urandom_range(1, 10));
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0 && pending_keys.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
